>>> design/mqmf_pkg.sv
// ----------------------------------------------------------------------------
// mqmf_pkg
// Shared types, constants and helpers for the multi-queue message FIFO.
// ----------------------------------------------------------------------------
package mqmf_pkg;

    // Sizing
    localparam int QUEUE_COUNT = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;

    localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W = $clog2(QUEUE_COUNT * QUEUE_DEPTH);
    localparam int PRM_W  = 16;
    localparam int ENTRY_W = ID_BITS + PRM_W;

    // APB register map
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_EMPTY_ID = 2'd0;

    typedef logic [QIDX_W-1:0]  qidx_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ID_BITS-1:0] msg_id_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // Operation codes
    typedef enum logic [2:0] {
        OP_POST        = 3'd0,
        OP_POST_UNIQUE = 3'd1,
        OP_INSERT      = 3'd2,
        OP_GET         = 3'd3,
        OP_PEEK        = 3'd4,
        OP_CLEAR       = 3'd5
    } op_code_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DROPPED = 2'd1,
        ST_DUP     = 2'd2,
        ST_EVICTED = 2'd3
    } status_code_t;

    // Result source select
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_EMPTY,
        RES_HEAD
    } res_sel_t;

    // Input transaction
    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  queue_sel;
        logic [7:0]  msg_id_in;
        logic [15:0] msg_param_in;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic        msg_valid;
        logic [7:0]  msg_id_out;
        logic [15:0] msg_param_out;
        logic [1:0]  status;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic         load_item;
        logic         start_scan;
        logic         scan_step;
        logic         do_post;
        logic         do_insert;
        logic         rd_head;
        logic         pop;
        logic         clear_q;
        logic         res_set;
        res_sel_t     res_sel;
        status_code_t res_status;
        logic         load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic       q_ok;
        logic       q_full;
        logic       q_empty;
        logic       dup_hit;
        logic       scan_done;
        logic       out_free;
    } stat_t;

    // Circular index helpers
    function automatic idx_t idx_inc(input idx_t i);
        idx_t r;
        if (i == idx_t'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

    function automatic idx_t idx_dec(input idx_t i);
        idx_t r;
        if (i == '0) begin
            r = idx_t'(QUEUE_DEPTH - 1);
        end else begin
            r = i - idx_t'(1);
        end
        return r;
    endfunction

    // Flat memory address of a slot within a queue
    function automatic addr_t slot_addr(input qidx_t q, input idx_t i);
        return addr_t'(addr_t'(q) * addr_t'(QUEUE_DEPTH)) + addr_t'(i);
    endfunction

endpackage

>>> design/mqmf_ctrl.sv
// ----------------------------------------------------------------------------
// mqmf_ctrl
// Sequencer: accepts one transaction, steps the datapath through the
// operation and hands the result to the output register.
// ----------------------------------------------------------------------------
module mqmf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mqmf_pkg::stat_t stat,
    output mqmf_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_HEAD,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Command decode
    always_comb begin
        cmd        = '0;
        cmd.res_sel    = mqmf_pkg::RES_ZERO;
        cmd.res_status = mqmf_pkg::ST_DONE;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESULT;
                cmd.res_set = 1'b1;
                if (!stat.q_ok) begin
                    cmd.res_sel = mqmf_pkg::RES_ZERO;
                end else begin
                    unique case (stat.op)
                        mqmf_pkg::OP_POST: begin
                            if (stat.q_full) begin
                                cmd.res_status = mqmf_pkg::ST_DROPPED;
                            end else begin
                                cmd.do_post = 1'b1;
                            end
                        end
                        mqmf_pkg::OP_POST_UNIQUE: begin
                            if (stat.q_full) begin
                                cmd.res_status = mqmf_pkg::ST_DROPPED;
                            end else begin
                                cmd.res_set    = 1'b0;
                                cmd.start_scan = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        mqmf_pkg::OP_INSERT: begin
                            cmd.do_insert = 1'b1;
                            if (stat.q_full) begin
                                cmd.res_status = mqmf_pkg::ST_EVICTED;
                            end
                        end
                        mqmf_pkg::OP_GET, mqmf_pkg::OP_PEEK: begin
                            if (stat.q_empty) begin
                                cmd.res_sel = mqmf_pkg::RES_EMPTY;
                            end else begin
                                cmd.res_set = 1'b0;
                                cmd.rd_head = 1'b1;
                                state_next  = S_HEAD;
                            end
                        end
                        mqmf_pkg::OP_CLEAR: begin
                            cmd.clear_q = 1'b1;
                        end
                        default: begin
                            cmd.res_sel = mqmf_pkg::RES_ZERO;
                        end
                    endcase
                end
            end
            // Duplicate scan over the live entries, one read per cycle
            S_SCAN: begin
                if (stat.dup_hit) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = mqmf_pkg::ST_DUP;
                    state_next     = S_RESULT;
                end else if (stat.scan_done) begin
                    cmd.do_post = 1'b1;
                    cmd.res_set = 1'b1;
                    state_next  = S_RESULT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            // Head entry is in the read register
            S_HEAD: begin
                cmd.res_set = 1'b1;
                cmd.res_sel = mqmf_pkg::RES_HEAD;
                cmd.pop     = (stat.op == mqmf_pkg::OP_GET);
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/mqmf_datapath.sv
// ----------------------------------------------------------------------------
// mqmf_datapath
// Entry memory, per-queue indexes and flags, duplicate compare, result
// staging and the output register.
// ----------------------------------------------------------------------------
module mqmf_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  mqmf_pkg::in_item_t  s_payload,
    input  logic [7:0]          empty_id,
    input  mqmf_pkg::cmd_t      cmd,
    output mqmf_pkg::stat_t     stat,
    input  logic                m_ready,
    output logic                m_valid,
    output mqmf_pkg::out_item_t m_payload
);

    // Entry memory
    mqmf_pkg::entry_t mem [mqmf_pkg::QUEUE_COUNT * mqmf_pkg::QUEUE_DEPTH];
    mqmf_pkg::entry_t rdata_reg;

    // Per-queue control state
    mqmf_pkg::idx_t widx_reg [mqmf_pkg::QUEUE_COUNT];
    mqmf_pkg::idx_t ridx_reg [mqmf_pkg::QUEUE_COUNT];
    logic           full_reg [mqmf_pkg::QUEUE_COUNT];
    logic           empty_reg [mqmf_pkg::QUEUE_COUNT];

    mqmf_pkg::in_item_t  item_reg;
    mqmf_pkg::idx_t      scan_ptr_reg;
    logic                scan_pend_reg;
    mqmf_pkg::out_item_t res_reg;
    mqmf_pkg::out_item_t res_next;
    logic                m_valid_reg;
    mqmf_pkg::out_item_t m_payload_reg;

    mqmf_pkg::qidx_t   q;
    mqmf_pkg::msg_id_t id_w;
    mqmf_pkg::entry_t  entry_w;
    mqmf_pkg::idx_t    w_cur;
    mqmf_pkg::idx_t    r_cur;
    logic              full_cur;
    logic              scan_issue;
    mqmf_pkg::idx_t    post_w_next;
    mqmf_pkg::idx_t    ins_w_next;
    mqmf_pkg::idx_t    ins_r_next;
    mqmf_pkg::idx_t    pop_r_next;
    logic              wr_en;
    mqmf_pkg::addr_t   wr_addr;
    logic              rd_en;
    mqmf_pkg::addr_t   rd_addr;
    mqmf_pkg::msg_id_t rd_id;

    // Current transaction view
    assign q        = mqmf_pkg::qidx_t'(item_reg.queue_sel);
    assign id_w     = mqmf_pkg::msg_id_t'(item_reg.msg_id_in);
    assign entry_w  = {id_w, item_reg.msg_param_in};
    assign w_cur    = widx_reg[q];
    assign r_cur    = ridx_reg[q];
    assign full_cur = full_reg[q];
    assign rd_id    = rdata_reg[mqmf_pkg::ENTRY_W-1:mqmf_pkg::PRM_W];

    // Index arithmetic for each update
    assign post_w_next = mqmf_pkg::idx_inc(w_cur);
    assign ins_w_next  = full_cur ? mqmf_pkg::idx_dec(w_cur) : w_cur;
    assign ins_r_next  = mqmf_pkg::idx_dec(r_cur);
    assign pop_r_next  = mqmf_pkg::idx_inc(r_cur);

    // Status back to the controller
    assign stat.op        = item_reg.op;
    assign stat.q_ok      = (int'(item_reg.queue_sel) < mqmf_pkg::QUEUE_COUNT);
    assign stat.q_full    = full_cur;
    assign stat.q_empty   = empty_reg[q];
    assign stat.dup_hit   = scan_pend_reg && (rd_id == id_w);
    assign stat.scan_done = !scan_pend_reg && (scan_ptr_reg == w_cur);
    assign stat.out_free  = !m_valid_reg || m_ready;

    // Memory port muxing
    assign scan_issue = cmd.scan_step && (scan_ptr_reg != w_cur);
    assign wr_en      = cmd.do_post || cmd.do_insert;
    assign wr_addr    = cmd.do_insert ? mqmf_pkg::slot_addr(q, ins_r_next)
                                      : mqmf_pkg::slot_addr(q, w_cur);
    assign rd_en      = cmd.rd_head || scan_issue;
    assign rd_addr    = cmd.rd_head ? mqmf_pkg::slot_addr(q, r_cur)
                                    : mqmf_pkg::slot_addr(q, scan_ptr_reg);

    // Entry memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= entry_w;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Transaction capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_payload;
        end
    end

    // Per-queue indexes and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mqmf_pkg::QUEUE_COUNT; i++) begin
                widx_reg[i]  <= '0;
                ridx_reg[i]  <= '0;
                full_reg[i]  <= 1'b0;
                empty_reg[i] <= 1'b1;
            end
        end else begin
            priority if (cmd.clear_q) begin
                widx_reg[q]  <= '0;
                ridx_reg[q]  <= '0;
                full_reg[q]  <= 1'b0;
                empty_reg[q] <= 1'b1;
            end else if (cmd.do_post) begin
                widx_reg[q]  <= post_w_next;
                empty_reg[q] <= 1'b0;
                full_reg[q]  <= (post_w_next == r_cur);
            end else if (cmd.do_insert) begin
                widx_reg[q]  <= ins_w_next;
                ridx_reg[q]  <= ins_r_next;
                empty_reg[q] <= 1'b0;
                full_reg[q]  <= (ins_w_next == ins_r_next);
            end else if (cmd.pop) begin
                ridx_reg[q]  <= pop_r_next;
                full_reg[q]  <= 1'b0;
                empty_reg[q] <= (w_cur == pop_r_next);
            end else begin
                // hold
            end
        end
    end

    // Duplicate scan pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_ptr_reg  <= '0;
            scan_pend_reg <= 1'b0;
        end else if (cmd.start_scan) begin
            scan_ptr_reg  <= r_cur;
            scan_pend_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            scan_pend_reg <= scan_issue;
            if (scan_issue) begin
                scan_ptr_reg <= mqmf_pkg::idx_inc(scan_ptr_reg);
            end
        end
    end

    // Result staging
    always_comb begin
        res_next        = '0;
        res_next.status = cmd.res_status;
        unique case (cmd.res_sel)
            mqmf_pkg::RES_EMPTY: begin
                res_next.msg_id_out = empty_id;
            end
            mqmf_pkg::RES_HEAD: begin
                res_next.msg_valid     = 1'b1;
                res_next.msg_id_out    = 8'(rd_id);
                res_next.msg_param_out = rdata_reg[mqmf_pkg::PRM_W-1:0];
            end
            default: begin
                res_next.msg_id_out = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            res_reg <= res_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_payload_reg <= res_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

>>> design/multi_queue_message_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_message_fifo: one transaction in flight; a new transaction is
// accepted only after the result of the last one is loaded into the output
// register, which can stall on m_ready. post_unique scans the live entries of
// the queue, one scan read per cycle. Sync reset empties all queues and zeroes the
// empty-id register; entry memory is not cleared.
// ----------------------------------------------------------------------------
module multi_queue_message_fifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mqmf_pkg::in_item_t                 s_payload,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output mqmf_pkg::out_item_t                m_payload,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mqmf_pkg::PADDR_W-1:0]       paddr,
    input  logic [mqmf_pkg::PDATA_W-1:0]       pwdata,
    output logic [mqmf_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    logic           [7:0] empty_id_reg;
    mqmf_pkg::cmd_t       cmd;
    mqmf_pkg::stat_t      stat;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_id_reg <= '0;
        end else if (psel && penable && pwrite && (paddr == mqmf_pkg::ADDR_EMPTY_ID)) begin
            empty_id_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr == mqmf_pkg::ADDR_EMPTY_ID)
                  ? mqmf_pkg::PDATA_W'(empty_id_reg) : '0;

    // Sequencer
    mqmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Queue storage and result path
    mqmf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .empty_id  (empty_id_reg),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

endmodule
